// ----- rtl/hcbd_pkg.sv -----
// ----------------------------------------------------------------------------
// hcbd_pkg
// Types, constants and helper functions shared by the chunked body decoder.
// ----------------------------------------------------------------------------
package hcbd_pkg;

  // length counters, size accumulator and running total
  localparam int LEN_BITS = 24;

  localparam int BODY_LIMIT_W = 24;
  localparam int LINE_LIMIT_W = 16;
  localparam int CFG_DATA_W   = 24;
  localparam int CFG_ADDR_W   = 1;

  // size + total compare width, wide enough for the sum and for body_limit
  localparam int CMP_W = (LEN_BITS + 2 > BODY_LIMIT_W + 1) ? LEN_BITS + 2 : BODY_LIMIT_W + 1;

  localparam logic [BODY_LIMIT_W-1:0] BODY_LIMIT_RST = BODY_LIMIT_W'(10 * 1024 * 1024);
  localparam logic [LINE_LIMIT_W-1:0] LINE_LIMIT_RST = LINE_LIMIT_W'(16 * 1024);

  // saturation value of the size accumulator
  localparam logic [LEN_BITS:0] LEN_CAP = {1'b1, {LEN_BITS{1'b0}}};

  localparam logic [CFG_ADDR_W-1:0] REG_BODY_LIMIT = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_LINE_LIMIT = CFG_ADDR_W'(1);

  localparam logic [7:0] CHR_CR  = 8'h0D;
  localparam logic [7:0] CHR_LF  = 8'h0A;
  localparam logic [7:0] CHR_SP  = 8'h20;
  localparam logic [7:0] CHR_TAB = 8'h09;

  typedef enum logic [2:0] {
    PH_SIZE  = 3'd0,
    PH_DATA  = 3'd1,
    PH_DCR   = 3'd2,
    PH_DLF   = 3'd3,
    PH_TRAIL = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    DG_NONE    = 2'd0,
    DG_DIGITS  = 2'd1,
    DG_AFTER   = 2'd2,
    DG_INVALID = 2'd3
  } digit_e;

  typedef enum logic [1:0] {
    ST_RUN = 2'd0,
    ST_OK  = 2'd1,
    ST_BAD = 2'd2,
    ST_BIG = 2'd3
  } status_e;

  typedef struct packed {
    digit_e          dp;
    logic [LEN_BITS:0] accum;
  } sizer_t;

  typedef struct packed {
    phase_e                  phase;
    digit_e                  dp;
    logic                    pending_cr;
    logic [LEN_BITS:0]       accum;
    logic [LEN_BITS-1:0]     bytes_left;
    logic [LEN_BITS-1:0]     total;
    logic [LINE_LIMIT_W-1:0] line_len;
    status_e                 status;
  } dec_state_t;

  typedef struct packed {
    logic [7:0] body_byte;
    logic       body_valid;
    status_e    status;
  } dec_result_t;

  // {is_hex, value}
  function automatic logic [4:0] hex_decode(input logic [7:0] b);
    logic [4:0] r;
    r = 5'b0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

  // one text byte of a size line
  function automatic sizer_t size_char(input sizer_t s, input logic [7:0] b);
    sizer_t            r;
    logic [4:0]        h;
    logic [LEN_BITS+4:0] v;
    r = s;
    h = hex_decode(b);
    v = {s.accum, 4'b0000} + (LEN_BITS+5)'(h[3:0]);
    unique case (s.dp)
      DG_NONE: begin
        if (b == CHR_SP || b == CHR_TAB) begin
          r = s;
        end else if (h[4]) begin
          r.accum = (LEN_BITS+1)'(h[3:0]);
          r.dp    = DG_DIGITS;
        end else begin
          r.dp = DG_INVALID;
        end
      end
      DG_DIGITS: begin
        if (h[4]) begin
          r.accum = (v > {4'b0000, LEN_CAP}) ? LEN_CAP : v[LEN_BITS:0];
        end else begin
          r.dp = DG_AFTER;
        end
      end
      default: r = s;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/http_chunked_body_decoder.sv -----
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// Decodes an HTTP/1.1 chunked body, one stream byte per transfer.
// ----------------------------------------------------------------------------
// Every input transfer carries one byte of the chunked stream and yields
// exactly one output transfer, in the cycle after acceptance, carrying the
// payload byte (flagged in tuser when it is chunk data) and the status:
// in progress, done, bad request or payload too large. Errors and done are
// sticky until reset. A new byte is accepted in every cycle; the only limit
// on throughput is the single output register, which frees when the
// downstream side takes its transfer. Configuration writes apply at once and
// are meant to happen while no transfer is in flight.
module http_chunked_body_decoder import hcbd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // config write port
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // stream in
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [7:0] data_byte
  input  logic                  s_axis_tuser,   // [0] stream_closed
  // stream out
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [15:0]           m_axis_tdata,   // [7:0] body_byte, [9:8] status
  output logic                  m_axis_tuser    // [0] body_valid
);

  logic [BODY_LIMIT_W-1:0] body_limit_q;
  logic [LINE_LIMIT_W-1:0] line_limit_q;
  dec_state_t              state_q, state_d;
  dec_result_t             res_d, res_q;
  logic                    out_valid_q;
  logic                    s_fire;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  hcbd_step u_step (
    .cur_i           (state_q),
    .data_byte_i     (s_axis_tdata),
    .stream_closed_i (s_axis_tuser),
    .body_limit_i    (body_limit_q),
    .line_limit_i    (line_limit_q),
    .nxt_o           (state_d),
    .res_o           (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      body_limit_q <= BODY_LIMIT_RST;
      line_limit_q <= LINE_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_BODY_LIMIT: body_limit_q <= BODY_LIMIT_W'(cfg_wdata_i);
        REG_LINE_LIMIT: line_limit_q <= cfg_wdata_i[LINE_LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: PH_SIZE, dp: DG_NONE, pending_cr: 1'b0, accum: '0,
                   bytes_left: '0, total: '0, line_len: '0, status: ST_RUN};
      out_valid_q <= 1'b0;
    end else begin
      if (s_fire) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (s_fire) res_q <= res_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b000000, res_q.status, res_q.body_byte};
  assign m_axis_tuser  = res_q.body_valid;

  // final status never changes once reached
  a_status_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.status != ST_RUN) |=> (state_q.status == $past(state_q.status)))
    else $error("final status changed");

  // payload bytes only while decoding is in progress
  a_payload_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.body_valid) |-> (res_q.status == ST_RUN))
    else $error("payload transfer with final status");

  // data phase always has bytes left to pass
  a_data_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.phase == PH_DATA) |-> (state_q.bytes_left != '0))
    else $error("data phase with zero byte count");

  // after completion no further payload leaves
  a_no_payload_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && state_q.status != ST_RUN) |=> !res_q.body_valid)
    else $error("payload after final status");

endmodule

// ----- rtl/hcbd_step.sv -----
// ----------------------------------------------------------------------------
// hcbd_step
// Single-pass update of the decoder state for one received byte, and the
// result that byte produces.
// ----------------------------------------------------------------------------
module hcbd_step import hcbd_pkg::*; (
  input  dec_state_t              cur_i,
  input  logic [7:0]              data_byte_i,
  input  logic                    stream_closed_i,
  input  logic [BODY_LIMIT_W-1:0] body_limit_i,
  input  logic [LINE_LIMIT_W-1:0] line_limit_i,
  output dec_state_t              nxt_o,
  output dec_result_t             res_o
);

  logic [CMP_W-1:0] sum_total;
  logic             too_big;

  assign sum_total = CMP_W'(cur_i.total) + CMP_W'(cur_i.accum);
  assign too_big   = (cur_i.accum >= LEN_CAP) ||
                     (sum_total > CMP_W'(body_limit_i)) ||
                     (sum_total >= CMP_W'(LEN_CAP));

  // next state
  always_comb begin
    sizer_t sc1;
    sizer_t sc2;
    nxt_o = cur_i;
    sc1   = '{dp: cur_i.dp, accum: cur_i.accum};
    sc2   = sc1;
    if (cur_i.status == ST_RUN) begin
      if (stream_closed_i) begin
        nxt_o.status = ST_BAD;
      end else begin
        unique case (cur_i.phase)
          PH_DATA: begin
            nxt_o.total      = cur_i.total + LEN_BITS'(1);
            nxt_o.bytes_left = (cur_i.bytes_left != '0) ?
                               cur_i.bytes_left - LEN_BITS'(1) : '0;
            if (cur_i.bytes_left <= LEN_BITS'(1)) begin
              nxt_o.phase = PH_DCR;
            end
          end
          PH_DCR: begin
            if (data_byte_i == CHR_CR) nxt_o.phase = PH_DLF;
            else nxt_o.status = ST_BAD;
          end
          PH_DLF: begin
            if (data_byte_i == CHR_LF) begin
              nxt_o.phase      = PH_SIZE;
              nxt_o.line_len   = '0;
              nxt_o.dp         = DG_NONE;
              nxt_o.accum      = '0;
              nxt_o.pending_cr = 1'b0;
            end else begin
              nxt_o.status = ST_BAD;
            end
          end
          PH_SIZE, PH_TRAIL: begin
            if (cur_i.pending_cr && data_byte_i == CHR_LF) begin
              // end of line
              nxt_o.pending_cr = 1'b0;
              if (cur_i.phase == PH_TRAIL) begin
                if (cur_i.line_len == LINE_LIMIT_W'(1)) nxt_o.status = ST_OK;
                nxt_o.line_len = '0;
                nxt_o.dp       = DG_NONE;
                nxt_o.accum    = '0;
              end else if (cur_i.dp == DG_NONE || cur_i.dp == DG_INVALID) begin
                nxt_o.status = ST_BAD;
              end else if (cur_i.accum == '0) begin
                nxt_o.phase    = PH_TRAIL;
                nxt_o.line_len = '0;
                nxt_o.dp       = DG_NONE;
              end else if (too_big) begin
                nxt_o.status = ST_BIG;
              end else begin
                nxt_o.bytes_left = cur_i.accum[LEN_BITS-1:0];
                nxt_o.phase      = PH_DATA;
                nxt_o.line_len   = '0;
                nxt_o.dp         = DG_NONE;
                nxt_o.accum      = '0;
              end
            end else begin
              // a lone cr counts as a text byte of a size line
              if (cur_i.pending_cr && cur_i.phase == PH_SIZE) begin
                sc1 = size_char(sc1, CHR_CR);
              end
              nxt_o.pending_cr = 1'b0;
              sc2 = sc1;
              if (cur_i.line_len >= line_limit_i) begin
                nxt_o.status = ST_BAD;
              end else begin
                nxt_o.line_len = cur_i.line_len + LINE_LIMIT_W'(1);
                if (data_byte_i == CHR_CR) begin
                  nxt_o.pending_cr = 1'b1;
                end else if (cur_i.phase == PH_SIZE) begin
                  sc2 = size_char(sc1, data_byte_i);
                end
              end
              nxt_o.dp    = sc2.dp;
              nxt_o.accum = sc2.accum;
            end
          end
          default: nxt_o.status = ST_BAD;
        endcase
      end
    end
  end

  // result
  always_comb begin
    res_o.body_valid = (cur_i.status == ST_RUN) && !stream_closed_i &&
                       (cur_i.phase == PH_DATA);
    res_o.body_byte  = res_o.body_valid ? data_byte_i : 8'h00;
    res_o.status     = nxt_o.status;
  end

endmodule
